[rtl/ufe_pkg.sv]
`timescale 1ns / 1ps

package ufe_pkg;

    localparam int ELEM_W           = 12;
    localparam int RANK_W           = 4;
    localparam int RED_K_W          = 4;
    localparam int DEFAULT_ELEMENTS = 4096;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    localparam logic [1:0] ACT_FIND  = 2'd0;
    localparam logic [1:0] ACT_SAME  = 2'd1;
    localparam logic [1:0] ACT_UNION = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
    } t_in_word;

    typedef struct packed {
        logic [ELEM_W-1:0] root_a;
        logic [ELEM_W-1:0] root_b;
        logic              same_set;
        logic              merged;
    } t_out_word;

    typedef struct packed {
        logic clear_step;
        logic load_in;
        logic red_step;
        logic seed_a;
        logic seed_b;
        logic walk_step;
        logic cmp_step;
        logic sel_b;
        logic rank_rd_b;
        logic link;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic red_last;
        logic walk_hit;
        logic cmp_done;
        logic is_pair;
        logic is_union;
        logic roots_eq;
    } t_dp_status;

    // number of conditional-subtract steps that reduce a 12-bit index below elements
    function automatic int red_steps(input int elements);
        int n;
        n = 0;
        for (int k = 0; k < ELEM_W; k++) begin
            if ((elements << k) < (1 << ELEM_W)) begin
                n++;
            end
        end
        return n;
    endfunction

endpackage

[rtl/ufe_datapath.sv]
`timescale 1ns / 1ps

module ufe_datapath #(
    parameter int ELEMENTS = ufe_pkg::DEFAULT_ELEMENTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ufe_pkg::t_in_word   i_in_data,
    input  ufe_pkg::t_dp_cmd    i_cmd,
    output ufe_pkg::t_dp_status o_status,
    output ufe_pkg::t_out_word  o_out_data
);

    localparam int IW        = $clog2(ELEMENTS);
    localparam int RED_STEPS = ufe_pkg::red_steps(ELEMENTS);
    localparam int RED_START = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
    localparam logic [ufe_pkg::ELEM_W-1:0] ELEM_LOW = ufe_pkg::ELEM_W'(ELEMENTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(ELEMENTS - 1);

    logic [IW-1:0]              r_parent_mem [ELEMENTS];
    logic [ufe_pkg::RANK_W-1:0] r_rank_mem   [ELEMENTS];

    logic [1:0]                 r_action;
    logic [ufe_pkg::ELEM_W-1:0] r_a_red;
    logic [ufe_pkg::ELEM_W-1:0] r_b_red;
    logic [ufe_pkg::RED_K_W-1:0] r_red_k;
    logic [IW-1:0]              r_cur;
    logic [IW-1:0]              r_pq;
    logic [IW-1:0]              r_root_a;
    logic [IW-1:0]              r_root_b;
    logic [IW-1:0]              r_clr;
    logic [ufe_pkg::RANK_W-1:0] r_rank_a;
    logic [ufe_pkg::RANK_W-1:0] r_rq;
    ufe_pkg::t_out_word         r_out;

    logic [IW-1:0]              idx_a;
    logic [IW-1:0]              idx_b;
    logic [IW-1:0]              start;
    logic [IW-1:0]              root_x;
    logic                       walk_hit;
    logic                       cmp_done;
    logic                       roots_eq;
    logic                       is_pair;
    logic                       is_union;
    logic                       rank_ge;
    logic [ufe_pkg::ELEM_W-1:0] sub;
    logic [IW-1:0]              p_rd_addr;
    logic                       p_wr_en;
    logic [IW-1:0]              p_wr_addr;
    logic [IW-1:0]              p_wr_data;
    logic [IW-1:0]              k_rd_addr;
    logic                       k_wr_en;
    logic [IW-1:0]              k_wr_addr;
    logic [ufe_pkg::RANK_W-1:0] k_wr_data;

    assign idx_a    = IW'(r_a_red);
    assign idx_b    = IW'(r_b_red);
    assign start    = i_cmd.sel_b ? idx_b : idx_a;
    assign root_x   = i_cmd.sel_b ? r_root_b : r_root_a;
    assign walk_hit = (r_pq == r_cur);
    assign cmp_done = (r_cur == root_x);
    assign roots_eq = (r_root_a == r_root_b);
    assign is_pair  = (r_action == ufe_pkg::ACT_SAME) || (r_action == ufe_pkg::ACT_UNION);
    assign is_union = (r_action == ufe_pkg::ACT_UNION);
    assign rank_ge  = (r_rank_a >= r_rq);
    assign sub      = ELEM_LOW << r_red_k;

    always_comb begin
        if (i_cmd.seed_a) begin
            p_rd_addr = idx_a;
        end else if (i_cmd.seed_b) begin
            p_rd_addr = idx_b;
        end else if (i_cmd.walk_step && walk_hit) begin
            p_rd_addr = start;
        end else begin
            p_rd_addr = r_pq;
        end
    end

    always_comb begin
        p_wr_en   = 1'b0;
        p_wr_addr = r_clr;
        p_wr_data = r_clr;
        k_wr_en   = 1'b0;
        k_wr_addr = r_clr;
        k_wr_data = '0;
        if (i_cmd.clear_step) begin
            p_wr_en = 1'b1;
            k_wr_en = 1'b1;
        end else if (i_cmd.cmp_step && !cmp_done) begin
            p_wr_en   = 1'b1;
            p_wr_addr = r_cur;
            p_wr_data = root_x;
        end else if (i_cmd.link) begin
            p_wr_en = 1'b1;
            if (rank_ge) begin
                p_wr_addr = r_root_b;
                p_wr_data = r_root_a;
                if ((r_rank_a == r_rq) && (r_rank_a != ufe_pkg::RANK_MAX)) begin
                    k_wr_en   = 1'b1;
                    k_wr_addr = r_root_a;
                    k_wr_data = r_rank_a + 1'b1;
                end
            end else begin
                p_wr_addr = r_root_a;
                p_wr_data = r_root_b;
            end
        end
    end

    assign k_rd_addr = i_cmd.rank_rd_b ? r_root_b : r_root_a;

    always_ff @(posedge i_clk) begin
        if (p_wr_en) begin
            r_parent_mem[p_wr_addr] <= p_wr_data;
        end
        r_pq <= r_parent_mem[p_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (k_wr_en) begin
            r_rank_mem[k_wr_addr] <= k_wr_data;
        end
        r_rq <= r_rank_mem[k_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_in_data.action;
            r_a_red  <= i_in_data.elem_a;
            r_b_red  <= i_in_data.elem_b;
            r_red_k  <= ufe_pkg::RED_K_W'(RED_START);
        end
        if (i_cmd.red_step) begin
            if (r_a_red >= sub) begin
                r_a_red <= r_a_red - sub;
            end
            if (r_b_red >= sub) begin
                r_b_red <= r_b_red - sub;
            end
            r_red_k <= r_red_k - 1'b1;
        end
        if (i_cmd.seed_a) begin
            r_cur <= idx_a;
        end else if (i_cmd.seed_b) begin
            r_cur <= idx_b;
        end else if (i_cmd.walk_step) begin
            if (walk_hit) begin
                if (i_cmd.sel_b) begin
                    r_root_b <= r_cur;
                end else begin
                    r_root_a <= r_cur;
                end
                r_cur <= start;
            end else begin
                r_cur <= r_pq;
            end
        end else if (i_cmd.cmp_step && !cmp_done) begin
            r_cur <= r_pq;
        end
        if (i_cmd.rank_rd_b) begin
            r_rank_a <= r_rq;
        end
        if (i_cmd.out_load) begin
            r_out.root_a   <= ufe_pkg::ELEM_W'(r_root_a);
            r_out.root_b   <= is_pair ? ufe_pkg::ELEM_W'(r_root_b) : '0;
            r_out.same_set <= is_pair && roots_eq;
            r_out.merged   <= is_union && !roots_eq;
        end
    end

    assign o_status.clear_last = (r_clr == LAST_IDX);
    assign o_status.red_last   = (r_red_k == '0);
    assign o_status.walk_hit   = walk_hit;
    assign o_status.cmp_done   = cmp_done;
    assign o_status.is_pair    = is_pair;
    assign o_status.is_union   = is_union;
    assign o_status.roots_eq   = roots_eq;
    assign o_out_data          = r_out;

endmodule

[rtl/ufe_ctrl.sv]
`timescale 1ns / 1ps

module ufe_ctrl #(
    parameter int ELEMENTS = ufe_pkg::DEFAULT_ELEMENTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  ufe_pkg::t_dp_status i_status,
    output ufe_pkg::t_dp_cmd    o_cmd
);

    localparam int RED_STEPS = ufe_pkg::red_steps(ELEMENTS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_SEED_A,
        S_WALK_A,
        S_CMP_A,
        S_WALK_B,
        S_CMP_B,
        S_RANK_A,
        S_RANK_B,
        S_LINK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (RED_STEPS > 0) ? S_REDUCE : S_SEED_A;
                end
            end
            S_REDUCE: begin
                o_cmd.red_step = 1'b1;
                if (i_status.red_last) begin
                    n_state = S_SEED_A;
                end
            end
            S_SEED_A: begin
                o_cmd.seed_a = 1'b1;
                n_state = S_WALK_A;
            end
            S_WALK_A: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_hit) begin
                    n_state = S_CMP_A;
                end
            end
            S_CMP_A: begin
                o_cmd.cmp_step = 1'b1;
                if (i_status.cmp_done) begin
                    if (i_status.is_pair) begin
                        o_cmd.seed_b = 1'b1;
                        n_state = S_WALK_B;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK_B: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.sel_b     = 1'b1;
                if (i_status.walk_hit) begin
                    n_state = S_CMP_B;
                end
            end
            S_CMP_B: begin
                o_cmd.cmp_step = 1'b1;
                o_cmd.sel_b    = 1'b1;
                if (i_status.cmp_done) begin
                    if (i_status.is_union && !i_status.roots_eq) begin
                        n_state = S_RANK_A;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RANK_A: begin
                n_state = S_RANK_B;
            end
            S_RANK_B: begin
                o_cmd.rank_rd_b = 1'b1;
                n_state = S_LINK;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/union_find_engine_unit.sv]
// Disjoint-set engine, union by rank with path compression.
// The engine takes one word at a time: a new word is accepted only once the result of the
// last one is in the output register; a stalled result holds the engine in its last state.
// Element indices are first reduced below ELEMENTS by conditional subtracts (none at 4096 and up).
// Reset (synchronous, active low) clears every parent and rank entry; input stalls till done.
`timescale 1ns / 1ps

module union_find_engine_unit #(
    parameter int ELEMENTS = ufe_pkg::DEFAULT_ELEMENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ufe_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ufe_pkg::t_out_word o_out_data
);

    ufe_pkg::t_dp_cmd    cmd;
    ufe_pkg::t_dp_status status;

    ufe_ctrl #(
        .ELEMENTS(ELEMENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ufe_datapath #(
        .ELEMENTS(ELEMENTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

[sim/ufe_checker.sv]
`timescale 1ns / 1ps

module ufe_checker #(
    parameter int ELEMENTS = ufe_pkg::DEFAULT_ELEMENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  ufe_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  ufe_pkg::t_out_word i_out_data,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    logic [ufe_pkg::ELEM_W-1:0] parent_of [ELEMENTS];
    logic [ufe_pkg::RANK_W-1:0] rank_of [ELEMENTS];

    ufe_pkg::t_out_word due_answers[$];
    ufe_pkg::t_out_word want;
    int                 bad_count = 0;

    initial begin
        for (int i = 0; i < ELEMENTS; i++) begin
            parent_of[i] = ufe_pkg::ELEM_W'(i);
            rank_of[i]   = '0;
        end
    end

    function automatic logic [ufe_pkg::ELEM_W-1:0] reduce_index(
            input logic [ufe_pkg::ELEM_W-1:0] idx);
        return ufe_pkg::ELEM_W'(int'(idx) % ELEMENTS);
    endfunction

    // walk up to the root, then point every entry on the path straight at it
    function automatic logic [ufe_pkg::ELEM_W-1:0] root_compress(
            input logic [ufe_pkg::ELEM_W-1:0] start);
        logic [ufe_pkg::ELEM_W-1:0] r;
        logic [ufe_pkg::ELEM_W-1:0] x;
        logic [ufe_pkg::ELEM_W-1:0] nxt;
        int                         steps;
        r     = start;
        steps = 0;
        while (parent_of[r] != r && steps < ELEMENTS) begin
            r = parent_of[r];
            steps++;
        end
        x = start;
        while (x != r) begin
            nxt          = parent_of[x];
            parent_of[x] = r;
            x            = nxt;
        end
        return r;
    endfunction

    function automatic ufe_pkg::t_out_word dsu_apply(input ufe_pkg::t_in_word w);
        ufe_pkg::t_out_word         res;
        logic [ufe_pkg::ELEM_W-1:0] ra;
        logic [ufe_pkg::ELEM_W-1:0] rb;
        res        = '0;
        ra         = root_compress(reduce_index(w.elem_a));
        res.root_a = ra;
        if (w.action == ufe_pkg::ACT_SAME || w.action == ufe_pkg::ACT_UNION) begin
            rb           = root_compress(reduce_index(w.elem_b));
            res.root_b   = rb;
            res.same_set = (ra == rb);
            if (w.action == ufe_pkg::ACT_UNION && ra != rb) begin
                if (rank_of[ra] >= rank_of[rb]) begin
                    parent_of[rb] = ra;
                    if (rank_of[ra] == rank_of[rb] && rank_of[ra] != ufe_pkg::RANK_MAX) begin
                        rank_of[ra] = rank_of[ra] + 1'b1;
                    end
                end else begin
                    parent_of[ra] = rb;
                end
                res.merged = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input ufe_pkg::t_out_word exp_w,
                                 input ufe_pkg::t_out_word got_w);
        bad_count++;
        if (bad_count <= 10) begin
            $display("%0t %s: expected root_a=%0h root_b=%0h same=%0b merged=%0b,",
                     $time, what, exp_w.root_a, exp_w.root_b, exp_w.same_set, exp_w.merged);
            $display("    got root_a=%0h root_b=%0h same=%0b merged=%0b",
                     got_w.root_a, got_w.root_b, got_w.same_set, got_w.merged);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                due_answers.push_back(dsu_apply(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_answers.size() == 0) begin
                    note_mismatch("unexpected word", '0, i_out_data);
                end else begin
                    want = due_answers.pop_front();
                    if (i_out_data.root_a != want.root_a
                            || i_out_data.root_b != want.root_b
                            || i_out_data.same_set != want.same_set
                            || i_out_data.merged != want.merged) begin
                        note_mismatch("mismatch", want, i_out_data);
                    end
                end
            end
        end
        o_mismatches  <= bad_count;
        o_outstanding <= due_answers.size();
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int         ELEMENTS    = ufe_pkg::DEFAULT_ELEMENTS;
    localparam int         RAND_WORDS  = 900;
    localparam logic [1:0] ACT_SPARE   = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    ufe_pkg::t_in_word  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    ufe_pkg::t_out_word out_data;
    bit                 calm      = 1'b0;
    int                 mismatches;
    int                 outstanding;

    union_find_engine_unit #(.ELEMENTS(ELEMENTS)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    ufe_checker #(.ELEMENTS(ELEMENTS)) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 10);
    end

    function automatic ufe_pkg::t_in_word mk_word(input logic [1:0] act, input int a,
                                                  input int b);
        ufe_pkg::t_in_word w;
        w.action = act;
        w.elem_a = ufe_pkg::ELEM_W'(a);
        w.elem_b = ufe_pkg::ELEM_W'(b);
        return w;
    endfunction

    // mostly a narrow window so trees grow deep, sometimes anywhere
    function automatic int pick_elem(input int base, input int span);
        if ($urandom_range(99) < 75) begin
            return (base + $urandom_range(span - 1)) % 4096;
        end
        return $urandom_range(4095);
    endfunction

    task automatic push_word(input ufe_pkg::t_in_word w);
        if (!calm && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        ufe_pkg::t_in_word directed[$];
        int                base;
        int                span;
        int                r;
        logic [1:0]        act;

        directed = {
            mk_word(ufe_pkg::ACT_FIND,  0,    4095),
            mk_word(ufe_pkg::ACT_FIND,  4095, 0),
            mk_word(ACT_SPARE,          7,    9),
            mk_word(ufe_pkg::ACT_UNION, 5,    5),
            mk_word(ufe_pkg::ACT_UNION, 0,    1),
            mk_word(ufe_pkg::ACT_UNION, 2,    3),
            mk_word(ufe_pkg::ACT_UNION, 1,    3),
            mk_word(ufe_pkg::ACT_UNION, 4095, 3),
            mk_word(ufe_pkg::ACT_SAME,  3,    4095),
            mk_word(ufe_pkg::ACT_SAME,  0,    4094),
            mk_word(ufe_pkg::ACT_FIND,  3,    4095),
            mk_word(ufe_pkg::ACT_UNION, 4094, 4093),
            mk_word(ufe_pkg::ACT_UNION, 4092, 4091),
            mk_word(ufe_pkg::ACT_UNION, 4094, 4092),
            mk_word(ufe_pkg::ACT_UNION, 4091, 3),
            mk_word(ufe_pkg::ACT_FIND,  1,    0),
            mk_word(ufe_pkg::ACT_SAME,  4095, 4093),
            mk_word(ufe_pkg::ACT_UNION, 4095, 4093),
            mk_word(ACT_SPARE,          4095, 4095),
            mk_word(ufe_pkg::ACT_SAME,  4095, 4095),
            mk_word(ufe_pkg::ACT_UNION, 6,    4095)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i]) push_word(directed[i]);

        base = 0;
        span = 16;
        for (int i = 0; i < RAND_WORDS; i++) begin
            calm = (i >= 300 && i < 450);
            if (i % 100 == 0) begin
                base = $urandom_range(4095);
                case ($urandom_range(2))
                    0: span = 16;
                    1: span = 64;
                    default: span = 256;
                endcase
            end
            r = $urandom_range(99);
            if (r < 45) begin
                act = ufe_pkg::ACT_UNION;
            end else if (r < 70) begin
                act = ufe_pkg::ACT_SAME;
            end else if (r < 95) begin
                act = ufe_pkg::ACT_FIND;
            end else begin
                act = ACT_SPARE;
            end
            push_word(mk_word(act, pick_elem(base, span), pick_elem(base, span)));
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/ufe_pkg.sv
rtl/ufe_datapath.sv
rtl/ufe_ctrl.sv
rtl/union_find_engine_unit.sv
sim/ufe_checker.sv
sim/testbench.sv
